// ===== rtl/m3sp_pkg.sv =====
// ---------------------------------------------------------------------------
// m3sp_pkg: shared types and constants of the M3UA stream parser
// Result word layout, item kinds, status codes, register indexes and queue
// sizing used by the parser front end, the result queue and the output stage.
// ---------------------------------------------------------------------------
`default_nettype none

package m3sp_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RC_TAG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HB_TAG   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PD_TAG   = 2'd3;
    localparam int CFG_DATA_W = 16;

    // register reset values
    localparam logic [7:0]  RST_VERSION = 8'd1;
    localparam logic [15:0] RST_RC_TAG  = 16'd6;
    localparam logic [15:0] RST_HB_TAG  = 16'd9;
    localparam logic [15:0] RST_PD_TAG  = 16'd528;

    // framing constants
    localparam logic [31:0] HDR_LEN      = 32'd8;
    localparam logic [15:0] TLV_HDR_LEN  = 16'd4;
    localparam logic [15:0] PD_FIXED_LEN = 16'd12;

    // result queue sizing
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_HEARTBEAT = 2'd0,
        KIND_USER_DATA = 2'd1,
        KIND_SUMMARY   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_VERSION = 3'd1,
        ST_SHORT_MSG   = 3'd2,
        ST_SHORT_TLV   = 3'd3,
        ST_TLV_OVERRUN = 3'd4,
        ST_PD_SHORT    = 3'd5
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [7:0]  message_class;
        logic [7:0]  message_type;
        logic        context_present;
        logic [31:0] routing_context;
        logic        payload_present;
        logic [31:0] origin_point_code;
        logic [31:0] destination_point_code;
        logic [31:0] service_octets;
        t_status     status;
    } t_item;

    // push control from the parser to the queue
    typedef struct packed {
        logic first;
        logic second;
    } t_push;

endpackage

`default_nettype wire

// ===== rtl/m3sp_front.sv =====
// ---------------------------------------------------------------------------
// m3sp_front: byte parser
// Frames messages, walks TLVs and produces up to two result words per byte
// (a data word and/or the end-of-message summary). Holds the config registers.
// ---------------------------------------------------------------------------
`default_nettype none

module m3sp_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_accept,
    input  wire logic [7:0]                      i_byte,
    input  wire logic                            i_cfg_we,
    input  wire logic [m3sp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [m3sp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output m3sp_pkg::t_push                      o_push,
    output m3sp_pkg::t_item                      o_item_a,
    output m3sp_pkg::t_item                      o_item_b
);
    import m3sp_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_TLV_HDR = 3'd1,
        PH_VALUE   = 3'd2,
        PH_PAD     = 3'd3,
        PH_SKIP    = 3'd4
    } t_phase;

    // config registers
    logic [7:0]  r_exp_ver;
    logic [15:0] r_rc_tag, r_hb_tag, r_pd_tag;

    // parse state
    t_phase      r_phase, n_phase;
    logic [31:0] r_msg_pos, n_msg_pos;
    logic [31:0] r_msg_len, n_msg_len;
    logic [7:0]  r_hdr_ver, n_hdr_ver;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_tag, n_tag;
    logic [15:0] r_tlen, n_tlen;
    logic [15:0] r_vpos, n_vpos;
    logic [31:0] r_asm, n_asm;
    logic [31:0] r_ctx, n_ctx;
    logic        r_ctx_vld, n_ctx_vld;
    logic [31:0] r_opc, n_opc;
    logic [31:0] r_dpc, n_dpc;
    logic [31:0] r_svc, n_svc;
    logic        r_pd_vld, n_pd_vld;
    t_status     r_status, n_status;

    // next phase at body offset nxt: a TLV header if at least four bytes remain, else skip
    function automatic t_phase f_tlv_start(input logic [31:0] nxt, input logic [31:0] len);
        logic [32:0] sum;
        sum = {1'b0, nxt} + 33'd4;
        return (sum <= {1'b0, len}) ? PH_TLV_HDR : PH_SKIP;
    endfunction

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_ver <= RST_VERSION;
            r_rc_tag  <= RST_RC_TAG;
            r_hb_tag  <= RST_HB_TAG;
            r_pd_tag  <= RST_PD_TAG;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_VERSION: r_exp_ver <= i_cfg_data[7:0];
                CFG_RC_TAG:  r_rc_tag  <= i_cfg_data;
                CFG_HB_TAG:  r_hb_tag  <= i_cfg_data;
                CFG_PD_TAG:  r_pd_tag  <= i_cfg_data;
                default:     r_exp_ver <= r_exp_ver;
            endcase
        end
    end

    // next-state and result logic for one byte
    logic [31:0] nxt;
    logic        done, data_v, sum_v;
    logic        is_rc, is_hb, is_pd;
    logic [15:0] vlen;
    logic [32:0] end_sum;
    t_kind       data_kind;
    t_item       data_item, sum_item;

    always_comb begin
        n_phase   = r_phase;   n_msg_pos = r_msg_pos; n_msg_len = r_msg_len;
        n_hdr_ver = r_hdr_ver; n_class   = r_class;   n_type    = r_type;
        n_tag     = r_tag;     n_tlen    = r_tlen;    n_vpos    = r_vpos;
        n_asm     = r_asm;     n_ctx     = r_ctx;     n_ctx_vld = r_ctx_vld;
        n_opc     = r_opc;     n_dpc     = r_dpc;     n_svc     = r_svc;
        n_pd_vld  = r_pd_vld;  n_status  = r_status;
        nxt       = r_msg_pos + 32'd1;
        done      = 1'b0;
        data_v    = 1'b0;
        data_kind = KIND_HEARTBEAT;
        end_sum   = '0;

        is_rc = (r_tag == r_rc_tag);
        is_hb = !is_rc && (r_tag == r_hb_tag);
        is_pd = !is_rc && !is_hb && (r_tag == r_pd_tag);
        vlen  = (r_tlen >= TLV_HDR_LEN) ? r_tlen - TLV_HDR_LEN : 16'd0;

        if (r_phase == PH_HEADER) begin
            // common header bytes
            if (r_msg_pos == 32'd0) begin
                n_hdr_ver = '0; n_class = '0; n_type = '0; n_tag = '0; n_tlen = '0;
                n_vpos = '0; n_asm = '0; n_ctx = '0; n_ctx_vld = 1'b0; n_opc = '0;
                n_dpc = '0; n_svc = '0; n_pd_vld = 1'b0; n_status = ST_OK; n_msg_len = '0;
            end
            unique case (r_msg_pos)
                32'd0:   n_hdr_ver = i_byte;
                32'd2:   n_class   = i_byte;
                32'd3:   n_type    = i_byte;
                32'd4:   n_msg_len = {24'd0, i_byte};
                32'd5, 32'd6, 32'd7: n_msg_len = {r_msg_len[23:0], i_byte};
                default: n_msg_len = n_msg_len;
            endcase
            if (r_msg_pos >= 32'd7) begin
                if (n_hdr_ver != r_exp_ver) begin
                    if (n_status == ST_OK) n_status = ST_BAD_VERSION;
                    n_phase = PH_SKIP;
                    done    = (n_msg_len <= HDR_LEN);
                end else if (n_msg_len < HDR_LEN) begin
                    if (n_status == ST_OK) n_status = ST_SHORT_MSG;
                    n_phase = PH_SKIP;
                    done    = 1'b1;
                end else if (n_msg_len == HDR_LEN) begin
                    done = 1'b1;
                end else begin
                    n_vpos  = '0;
                    n_phase = f_tlv_start(HDR_LEN, n_msg_len);
                end
            end
            if (done) begin
                n_phase   = PH_HEADER;
                n_msg_pos = '0;
            end else begin
                n_msg_pos = nxt;
            end
        end else begin
            unique case (r_phase)
                // TLV tag and length
                PH_TLV_HDR: begin
                    if (r_vpos < 16'd2) n_tag  = {r_tag[7:0], i_byte};
                    else                n_tlen = {r_tlen[7:0], i_byte};
                    n_vpos = r_vpos + 16'd1;
                    if (n_vpos >= TLV_HDR_LEN) begin
                        is_rc = (n_tag == r_rc_tag);
                        is_hb = !is_rc && (n_tag == r_hb_tag);
                        is_pd = !is_rc && !is_hb && (n_tag == r_pd_tag);
                        if (n_tlen < TLV_HDR_LEN) begin
                            if (n_status == ST_OK) n_status = ST_SHORT_TLV;
                            n_phase = PH_SKIP;
                        end else begin
                            vlen    = n_tlen - TLV_HDR_LEN;
                            end_sum = {1'b0, nxt} + {17'd0, vlen};
                            if (end_sum > {1'b0, r_msg_len}) begin
                                if (n_status == ST_OK) n_status = ST_TLV_OVERRUN;
                                n_phase = PH_SKIP;
                            end else if (is_pd && vlen < PD_FIXED_LEN) begin
                                if (n_status == ST_OK) n_status = ST_PD_SHORT;
                                n_phase = PH_SKIP;
                            end else if (vlen == 16'd0) begin
                                n_vpos  = '0;
                                n_phase = f_tlv_start(nxt, r_msg_len);
                            end else begin
                                n_vpos  = '0;
                                n_asm   = '0;
                                n_phase = PH_VALUE;
                            end
                        end
                    end
                end
                // TLV value bytes
                PH_VALUE: begin
                    if (is_rc) begin
                        if (vlen >= 16'd4 && r_vpos < 16'd4) begin
                            n_asm = {r_asm[23:0], i_byte};
                            if (r_vpos == 16'd3) begin
                                n_ctx     = n_asm;
                                n_ctx_vld = 1'b1;
                            end
                        end
                    end else if (is_hb) begin
                        data_v    = 1'b1;
                        data_kind = KIND_HEARTBEAT;
                    end else if (is_pd) begin
                        if (r_vpos < PD_FIXED_LEN) begin
                            n_asm = {r_asm[23:0], i_byte};
                            if (r_vpos == 16'd3) n_opc = n_asm;
                            else if (r_vpos == 16'd7) n_dpc = n_asm;
                            else if (r_vpos == 16'd11) begin
                                n_svc    = n_asm;
                                n_pd_vld = 1'b1;
                            end
                        end else begin
                            data_v    = 1'b1;
                            data_kind = KIND_USER_DATA;
                        end
                    end
                    n_vpos = r_vpos + 16'd1;
                    if (n_vpos >= vlen) begin
                        if (n_vpos[1:0] != 2'd0) begin
                            n_phase = PH_PAD;
                        end else begin
                            n_vpos  = '0;
                            n_phase = f_tlv_start(nxt, r_msg_len);
                        end
                    end
                end
                // padding up to a 4-byte boundary
                PH_PAD: begin
                    n_vpos = r_vpos + 16'd1;
                    if (n_vpos[1:0] == 2'd0) begin
                        n_vpos  = '0;
                        n_phase = f_tlv_start(nxt, r_msg_len);
                    end
                end
                PH_SKIP: n_phase = PH_SKIP;
                default: n_phase = PH_SKIP;
            endcase
            // message end
            if (nxt >= r_msg_len) begin
                done      = 1'b1;
                n_phase   = PH_HEADER;
                n_msg_pos = '0;
            end else begin
                n_msg_pos = nxt;
            end
        end
        sum_v = done;

        data_item              = '0;
        data_item.kind         = data_kind;
        data_item.payload_byte = i_byte;
        data_item.status       = ST_OK;

        sum_item.kind                   = KIND_SUMMARY;
        sum_item.payload_byte           = 8'd0;
        sum_item.message_class          = n_class;
        sum_item.message_type           = n_type;
        sum_item.context_present        = n_ctx_vld;
        sum_item.routing_context        = n_ctx;
        sum_item.payload_present        = n_pd_vld;
        sum_item.origin_point_code      = n_opc;
        sum_item.destination_point_code = n_dpc;
        sum_item.service_octets         = n_svc;
        sum_item.status                 = n_status;
    end

    // pack results: data word first, summary after it
    always_comb begin
        o_push.first  = i_accept && (data_v || sum_v);
        o_push.second = i_accept && data_v && sum_v;
        o_item_a      = data_v ? data_item : sum_item;
        o_item_b      = sum_item;
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_msg_pos <= '0; r_msg_len <= '0; r_hdr_ver <= '0;
            r_class <= '0; r_type <= '0; r_tag <= '0; r_tlen <= '0; r_vpos <= '0;
            r_asm <= '0; r_ctx <= '0; r_ctx_vld <= 1'b0; r_opc <= '0; r_dpc <= '0;
            r_svc <= '0; r_pd_vld <= 1'b0; r_status <= ST_OK;
        end else if (i_accept) begin
            r_phase <= n_phase; r_msg_pos <= n_msg_pos; r_msg_len <= n_msg_len;
            r_hdr_ver <= n_hdr_ver; r_class <= n_class; r_type <= n_type;
            r_tag <= n_tag; r_tlen <= n_tlen; r_vpos <= n_vpos; r_asm <= n_asm;
            r_ctx <= n_ctx; r_ctx_vld <= n_ctx_vld; r_opc <= n_opc; r_dpc <= n_dpc;
            r_svc <= n_svc; r_pd_vld <= n_pd_vld; r_status <= n_status;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/m3sp_fifo.sv =====
// ---------------------------------------------------------------------------
// m3sp_fifo: result queue
// Small queue between parser and output stage; takes up to two words per
// cycle and hands out one. Asks for a stall when fewer than two slots are free.
// ---------------------------------------------------------------------------
`default_nettype none

module m3sp_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire m3sp_pkg::t_push i_push,
    input  wire m3sp_pkg::t_item i_item_a,
    input  wire m3sp_pkg::t_item i_item_b,
    input  wire logic            i_pop,
    output m3sp_pkg::t_item      o_head,
    output logic                 o_not_empty,
    output logic                 o_full
);
    import m3sp_pkg::*;

    t_item                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, r_rd;
    logic [FIFO_CNT_W-1:0] r_cnt, n_cnt;
    logic [FIFO_PTR_W-1:0] wr_next;

    assign wr_next     = r_wr + FIFO_PTR_W'(1);
    assign o_head      = r_mem[r_rd];
    assign o_not_empty = (r_cnt != '0);
    assign o_full      = (r_cnt > FIFO_CNT_W'(FIFO_DEPTH - 2));

    // occupancy after pushes and pop
    always_comb begin
        n_cnt = r_cnt + FIFO_CNT_W'(i_push.first) + FIFO_CNT_W'(i_push.second)
              - FIFO_CNT_W'(i_pop);
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.first)  r_mem[r_wr]    <= i_item_a;
        if (i_push.second) r_mem[wr_next] <= i_item_b;
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + FIFO_PTR_W'(i_push.first) + FIFO_PTR_W'(i_push.second);
            r_rd  <= r_rd + FIFO_PTR_W'(i_pop);
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/m3sp_out.sv =====
// ---------------------------------------------------------------------------
// m3sp_out: output stage
// Registers one result word from the queue and holds it while the receiver
// stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module m3sp_out (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire m3sp_pkg::t_item i_head,
    input  wire logic            i_not_empty,
    input  wire logic            i_stall,
    output logic                 o_pop,
    output logic                 o_valid,
    output m3sp_pkg::t_item      o_item
);
    import m3sp_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_pop   = i_not_empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_not_empty;
        end
    end

    // word register
    always_ff @(posedge i_clk) begin
        if (o_pop) r_item <= i_head;
    end

endmodule

`default_nettype wire

// ===== rtl/m3ua_stream_parser_unit.sv =====
// ---------------------------------------------------------------------------
// m3ua_stream_parser_unit: M3UA message and TLV parser
// Takes one stream byte per word and gives heartbeat bytes, user data bytes
// and one summary word at the end of every message.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_stream_byte): one byte per
//   word, one word per clock when the output side keeps up.
//   Output channel (o_out_valid / i_out_stall / result fields): a word per
//   heartbeat byte, per user data byte past the 12 fixed bytes of a protocol
//   data parameter, and a summary at the last byte of each message.
//   Config channel (i_cfg_valid / o_cfg_ready): always ready; write only
//   while the block is idle.
//   Path: a result is written into the result queue when its byte is taken
//   and is then registered by the output stage before it is on the output.
//   Throughput: one byte per clock while o_in_stall is low. A byte that
//   closes a message while also giving a data word yields two words; the
//   four-word result queue absorbs them, and the output stage drains one
//   word per clock while the receiver does not stall.
//   Stall: when the receiver stalls, the output word holds and the queue
//   fills; once fewer than two slots are free o_in_stall rises.
//   Reset: synchronous, active low; registers return to their defaults and
//   the parser waits for the first header byte.
// ---------------------------------------------------------------------------
`default_nettype none

module m3ua_stream_parser_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [7:0]                      i_stream_byte,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [1:0]                           o_item_kind,
    output logic [7:0]                           o_payload_byte,
    output logic [7:0]                           o_message_class,
    output logic [7:0]                           o_message_type,
    output logic                                 o_context_present,
    output logic [31:0]                          o_routing_context,
    output logic                                 o_payload_present,
    output logic [31:0]                          o_origin_point_code,
    output logic [31:0]                          o_destination_point_code,
    output logic [31:0]                          o_service_octets,
    output logic [2:0]                           o_status,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [m3sp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [m3sp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import m3sp_pkg::*;

    t_push push;
    t_item item_a, item_b, head, out_item;
    logic  not_empty, full, pop, accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign accept      = i_in_valid && !full;

    m3sp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_stream_byte),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_item_a    (item_a),
        .o_item_b    (item_b)
    );

    m3sp_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item_a    (item_a),
        .i_item_b    (item_b),
        .i_pop       (pop),
        .o_head      (head),
        .o_not_empty (not_empty),
        .o_full      (full)
    );

    m3sp_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_not_empty (not_empty),
        .i_stall     (i_out_stall),
        .o_pop       (pop),
        .o_valid     (o_out_valid),
        .o_item      (out_item)
    );

    // result fields
    assign o_item_kind              = out_item.kind;
    assign o_payload_byte           = out_item.payload_byte;
    assign o_message_class          = out_item.message_class;
    assign o_message_type           = out_item.message_type;
    assign o_context_present        = out_item.context_present;
    assign o_routing_context        = out_item.routing_context;
    assign o_payload_present        = out_item.payload_present;
    assign o_origin_point_code      = out_item.origin_point_code;
    assign o_destination_point_code = out_item.destination_point_code;
    assign o_service_octets         = out_item.service_octets;
    assign o_status                 = out_item.status;

endmodule

`default_nettype wire

// ===== rtl/m3sp_checker.sv =====
// ---------------------------------------------------------------------------
// m3sp_checker: port-level checks
// Watches the top-level ports for result word consistency and handshake rules.
// ---------------------------------------------------------------------------
`default_nettype none

module m3sp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_item_kind,
    input wire logic [7:0]  o_payload_byte,
    input wire logic        o_context_present,
    input wire logic        o_payload_present,
    input wire logic [2:0]  o_status
);
    import m3sp_pkg::*;

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_item_kind)
            && $stable(o_payload_byte) && $stable(o_status))
        else $error("output word changed under stall");

    // data words carry no summary content
    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_item_kind != KIND_SUMMARY |->
            o_status == ST_OK && !o_context_present && !o_payload_present)
        else $error("data word carries summary fields");

    // every word has a defined kind code; a summary has a zero payload byte
    a_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_item_kind == KIND_HEARTBEAT || o_item_kind == KIND_USER_DATA
            || (o_item_kind == KIND_SUMMARY && o_payload_byte == 8'd0)))
        else $error("bad kind or nonzero summary payload");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind m3ua_stream_parser_unit m3sp_checker u_m3sp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_item_kind       (o_item_kind),
    .o_payload_byte    (o_payload_byte),
    .o_context_present (o_context_present),
    .o_payload_present (o_payload_present),
    .o_status          (o_status)
);

`default_nettype wire
